/* sv/pixel_frame_difference_top_assert.svh */
// assertion macros used by the frame difference top level
`ifndef PIXEL_FRAME_DIFFERENCE_TOP_ASSERT_SVH
`define PIXEL_FRAME_DIFFERENCE_TOP_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define PFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pfd_pkg.sv */
// package: types, codes and helpers of the frame difference block
`default_nettype none
package pfd_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int TOTAL_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int SUM_W       = SAMPLE_W + 2;

  localparam logic [SAMPLE_W-1:0] MASK_CHANGED = 8'd255;
  localparam logic [SAMPLE_W-1:0] MAG_LIMIT    = 8'd255;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE = 2'd2;

  typedef enum logic {
    MODE_COUNT     = 1'b0,
    MODE_MAGNITUDE = 1'b1
  } compare_mode_t;

  typedef enum logic [1:0] {
    CH_ALL = 2'd0,
    CH_Y   = 2'd1,
    CH_U   = 2'd2,
    CH_V   = 2'd3
  } channel_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    compare_mode_t       compare_mode;
    channel_mode_t       channel_mode;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first_luma;
    logic [SAMPLE_W-1:0] first_cb;
    logic [SAMPLE_W-1:0] first_cr;
    logic [SAMPLE_W-1:0] second_luma;
    logic [SAMPLE_W-1:0] second_cb;
    logic [SAMPLE_W-1:0] second_cr;
    logic                last_pixel;
  } pix_t;

  // absolute difference of one channel, less the threshold in count mode
  function automatic logic [SAMPLE_W-1:0] chan_value(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic [SAMPLE_W-1:0] thr,
    input logic                count
  );
    logic [SAMPLE_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    if (count) begin
      d = (d > thr) ? (d - thr) : '0;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* sv/pfd_if.sv */
// channel interfaces: pixel input, result output and configuration writes
`default_nettype none
interface pfd_pixel_if import pfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] first_luma;
  logic [SAMPLE_W-1:0] first_cb;
  logic [SAMPLE_W-1:0] first_cr;
  logic [SAMPLE_W-1:0] second_luma;
  logic [SAMPLE_W-1:0] second_cb;
  logic [SAMPLE_W-1:0] second_cr;
  logic                last_pixel;

  modport source (
    output valid, first_luma, first_cb, first_cr,
           second_luma, second_cb, second_cr, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, first_luma, first_cb, first_cr,
           second_luma, second_cb, second_cr, last_pixel,
    output ready
  );
endinterface

interface pfd_result_if import pfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mask_value;
  logic [TOTAL_W-1:0]  difference_total;
  logic                frame_done;

  modport source (
    output valid, mask_value, difference_total, frame_done,
    input  ready
  );
  modport sink (
    input  valid, mask_value, difference_total, frame_done,
    output ready
  );
endinterface

interface pfd_cfg_if import pfd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/pfd_diff.sv */
// per-pixel difference: channel select, threshold, mask and total increment
`default_nettype none
module pfd_diff import pfd_pkg::*; (
  input  cfg_t                cfg,
  input  pix_t                pix,
  output logic [SAMPLE_W-1:0] mask,
  output logic [SAMPLE_W-1:0] add
);

  logic                count;
  logic [SAMPLE_W-1:0] dy;
  logic [SAMPLE_W-1:0] du;
  logic [SAMPLE_W-1:0] dv;
  logic [SUM_W-1:0]    sum;

  assign count = (cfg.compare_mode == MODE_COUNT);
  assign dy = chan_value(pix.first_luma, pix.second_luma, cfg.threshold, count);
  assign du = chan_value(pix.first_cb, pix.second_cb, cfg.threshold, count);
  assign dv = chan_value(pix.first_cr, pix.second_cr, cfg.threshold, count);

  always_comb begin
    case (cfg.channel_mode)
      CH_Y:    sum = {2'b00, dy};
      CH_U:    sum = {2'b00, du};
      CH_V:    sum = {2'b00, dv};
      default: sum = {2'b00, dy} + {2'b00, du} + {2'b00, dv};
    endcase
  end

  always_comb begin
    if (count) begin
      add  = (sum != '0) ? SAMPLE_W'(1) : '0;
      mask = (sum != '0) ? MASK_CHANGED : '0;
    end else begin
      add  = (sum > SUM_W'(MAG_LIMIT)) ? MAG_LIMIT : sum[SAMPLE_W-1:0];
      mask = add;
    end
  end

endmodule
`default_nettype wire

/* sv/pixel_frame_difference_top.sv */
// top level of the frame difference block: registers, flow control, running total
//
// usage
//   pixel   : one transfer per pixel, carrying the Y, U and V samples of both
//             frames and a last_pixel flag on the final pixel of the frame
//   result  : one transfer per pixel: mask byte, running frame total that
//             includes this pixel, and frame_done copied from last_pixel
//   cfg     : register writes (0 threshold, 1 compare_mode, 2 channel_mode),
//             always ready; an index past the list is dropped; write only
//             while no pixel is in flight
// timing
//   two register stages: input register, then result register; a pixel
//   passes from the input register to the result register, then shows on result
//   throughput is one pixel per clock while result is not held off; the
//   running total is updated in the result stage
// stall
//   when result is held off, the result register keeps its item and the
//   input register fills; pixel.ready drops once both hold data
// reset
//   rst is synchronous, active high; clears the stage valids, the running
//   total and the registers (threshold 0, count mode, all channels)
`default_nettype none
`include "pixel_frame_difference_top_assert.svh"
module pixel_frame_difference_top import pfd_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  pfd_cfg_if.sink      cfg,
  pfd_pixel_if.sink    pixel,
  pfd_result_if.source result
);

  // configuration registers
  cfg_t cfg_regs;

  // input register stage
  logic s1_valid;
  pix_t s1_pix;

  // result register stage and frame state
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_mask;
  logic [TOTAL_W-1:0]  out_total;
  logic                out_done;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_next;
  logic [TOTAL_W:0]    total_wide;

  // flow control
  logic out_load;
  logic s1_load;

  logic [SAMPLE_W-1:0] pix_mask;
  logic [SAMPLE_W-1:0] pix_add;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.threshold    <= '0;
      cfg_regs.compare_mode <= MODE_COUNT;
      cfg_regs.channel_mode <= CH_ALL;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD:    cfg_regs.threshold    <= cfg.data[SAMPLE_W-1:0];
        REG_COMPARE_MODE: cfg_regs.compare_mode <= compare_mode_t'(cfg.data[0]);
        REG_CHANNEL_MODE: cfg_regs.channel_mode <= channel_mode_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  // result register frees when empty or when its item is taken
  assign out_load    = s1_valid && (!out_valid || result.ready);
  assign s1_load     = pixel.valid && pixel.ready;
  assign pixel.ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix.first_luma  <= pixel.first_luma;
      s1_pix.first_cb    <= pixel.first_cb;
      s1_pix.first_cr    <= pixel.first_cr;
      s1_pix.second_luma <= pixel.second_luma;
      s1_pix.second_cb   <= pixel.second_cb;
      s1_pix.second_cr   <= pixel.second_cr;
      s1_pix.last_pixel  <= pixel.last_pixel;
    end
  end

  pfd_diff u_diff (
    .cfg  (cfg_regs),
    .pix  (s1_pix),
    .mask (pix_mask),
    .add  (pix_add)
  );

  // saturating accumulate
  assign total_wide = {1'b0, total} + {{(TOTAL_W + 1 - SAMPLE_W){1'b0}}, pix_add};
  assign total_next = total_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : total_wide[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        // frame total restarts after the last pixel
        total     <= s1_pix.last_pixel ? '0 : total_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask  <= pix_mask;
      out_total <= total_next;
      out_done  <= s1_pix.last_pixel;
    end
  end

  assign result.valid            = out_valid;
  assign result.mask_value       = out_mask;
  assign result.difference_total = out_total;
  assign result.frame_done       = out_done;

  // checks
  `PFD_ASSERT_NEXT(a_frame_clear, out_load && s1_pix.last_pixel, total == '0, "total not cleared after last pixel")
  `PFD_ASSERT_NEXT(a_total_rises, out_load && !s1_pix.last_pixel, total >= $past(total), "running total fell inside a frame")
  `PFD_ASSERT_NEXT(a_result_total, out_load, out_total == total || out_done, "result total differs from running total")
  `PFD_ASSERT_NOW(a_count_mask, out_valid && cfg_regs.compare_mode == MODE_COUNT, out_mask == '0 || out_mask == MASK_CHANGED, "count mode mask not binary")
  `PFD_ASSERT_NEXT(a_s1_hold, s1_valid && !out_load, s1_valid && $stable(s1_pix), "input register lost a held pixel")

endmodule
`default_nettype wire

/* sim/pixel_frame_difference_checker.sv */
// checker for the frame difference block: predicts every result and compares it
module pixel_frame_difference_checker import pfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pix_valid,
  input  logic                   pix_ready,
  input  pix_t                   pix,
  input  logic                   res_valid,
  input  logic                   res_ready,
  input  logic [SAMPLE_W-1:0]    res_mask,
  input  logic [TOTAL_W-1:0]     res_total,
  input  logic                   res_done,
  output int unsigned            mismatches,
  output int unsigned            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mask_value;
    logic [TOTAL_W-1:0]  difference_total;
    logic                frame_done;
  } pixel_outcome_t;

  pixel_outcome_t      awaited_outcomes[$];
  logic [SAMPLE_W-1:0] threshold_copy;
  compare_mode_t       compare_copy;
  channel_mode_t       channel_copy;
  logic [TOTAL_W-1:0]  frame_total;
  int unsigned         result_no;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $realtime, result_no, what);
    mismatches++;
  endtask

  // absolute difference of one channel, less the threshold in count mode
  function automatic logic [SUM_W-1:0] channel_gap(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] gap;
    gap = (a > b) ? a - b : b - a;
    if (compare_copy == MODE_COUNT) begin
      gap = (gap > threshold_copy) ? gap - threshold_copy : '0;
    end
    return SUM_W'(gap);
  endfunction

  // expected result of one pixel; advances the frame total
  function automatic pixel_outcome_t judge_pixel(input pix_t p);
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] add;
    pixel_outcome_t     o;
    case (channel_copy)
      CH_Y:    sum = channel_gap(p.first_luma, p.second_luma);
      CH_U:    sum = channel_gap(p.first_cb, p.second_cb);
      CH_V:    sum = channel_gap(p.first_cr, p.second_cr);
      default: sum = channel_gap(p.first_luma, p.second_luma)
                   + channel_gap(p.first_cb, p.second_cb)
                   + channel_gap(p.first_cr, p.second_cr);
    endcase
    if (compare_copy == MODE_COUNT) begin
      add          = (sum != '0) ? TOTAL_W'(1) : '0;
      o.mask_value = (sum != '0) ? MASK_CHANGED : '0;
    end else begin
      add          = (sum > MAG_LIMIT) ? TOTAL_W'(MAG_LIMIT) : TOTAL_W'(sum);
      o.mask_value = add[SAMPLE_W-1:0];
    end
    // saturates instead of wrapping
    if (frame_total > ~add) frame_total = '1;
    else frame_total = frame_total + add;
    o.difference_total = frame_total;
    o.frame_done       = p.last_pixel;
    if (p.last_pixel) frame_total = '0;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    pixel_outcome_t want;
    if (rst) begin
      threshold_copy = '0;
      compare_copy   = MODE_COUNT;
      channel_copy   = CH_ALL;
      frame_total    = '0;
      mismatches     = 0;
      result_no      = 0;
      awaited_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:    threshold_copy = cfg_data[SAMPLE_W-1:0];
          REG_COMPARE_MODE: compare_copy   = compare_mode_t'(cfg_data[0]);
          REG_CHANNEL_MODE: channel_copy   = channel_mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      // results leave before the pixel of this edge joins the queue
      if (res_valid && res_ready) begin
        if (awaited_outcomes.size() == 0) begin
          flag_mismatch("result with no pixel awaiting it");
        end else begin
          want = awaited_outcomes.pop_front();
          if (res_mask !== want.mask_value)
            flag_mismatch($sformatf("mask_value %0d, expected %0d",
                                    res_mask, want.mask_value));
          if (res_total !== want.difference_total)
            flag_mismatch($sformatf("difference_total %0d, expected %0d",
                                    res_total, want.difference_total));
          if (res_done !== want.frame_done)
            flag_mismatch($sformatf("frame_done %0b, expected %0b",
                                    res_done, want.frame_done));
        end
        result_no++;
      end
      if (pix_valid && pix_ready) awaited_outcomes.push_back(judge_pixel(pix));
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

/* sim/pixel_frame_difference_top_test.sv */
// testbench top: stimulus, flow control, watchdog and verdict for the frame difference block
module pixel_frame_difference_top_test import pfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the register list, must be dropped by the block
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RANDOM_ITEMS   = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // when set, neither side idles: back-to-back transfers
  bit          idle_free = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches;
  int unsigned pending;

  pfd_cfg_if    cfg_ch ();
  pfd_pixel_if  pix_ch ();
  pfd_result_if res_ch ();

  pixel_frame_difference_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixel  (pix_ch),
    .result (res_ch)
  );

  pixel_frame_difference_checker diff_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .pix_valid   (pix_ch.valid),
    .pix_ready   (pix_ch.ready),
    .pix         ({pix_ch.first_luma, pix_ch.first_cb, pix_ch.first_cr,
                   pix_ch.second_luma, pix_ch.second_cb, pix_ch.second_cr,
                   pix_ch.last_pixel}),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_mask    (res_ch.mask_value),
    .res_total   (res_ch.difference_total),
    .res_done    (res_ch.frame_done),
    .mismatches  (mismatches),
    .outstanding (pending)
  );

  always #5 clk = ~clk;

  // mostly short pauses, now and then a long one
  function automatic int unsigned pause_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // result side back-pressure: random holds unless the phase runs idle free
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!idle_free && $urandom_range(0, 3) == 0) hold_left <= pause_length();
    end
  end

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (pix_ch.valid && pix_ch.ready)
        || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pix_t pix_of(input logic [7:0] fy, input logic [7:0] fu,
                                  input logic [7:0] fv, input logic [7:0] sy,
                                  input logic [7:0] su, input logic [7:0] sv,
                                  input logic last);
    pix_t p;
    p = '{fy, fu, fv, sy, su, sv, last};
    return p;
  endfunction

  // second-frame sample: often a close neighbour so small thresholds matter
  function automatic logic [7:0] partner(input logic [7:0] s);
    if ($urandom_range(0, 1) == 0) return s + 8'($urandom_range(0, 12)) - 8'd6;
    return 8'($urandom);
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.first_luma  = 8'($urandom);
    p.first_cb    = 8'($urandom);
    p.first_cr    = 8'($urandom);
    p.second_luma = partner(p.first_luma);
    p.second_cb   = partner(p.first_cb);
    p.second_cr   = partner(p.first_cr);
    // an unchanged pixel now and then
    if ($urandom_range(0, 7) == 0) begin
      p.second_luma = p.first_luma;
      p.second_cb   = p.first_cb;
      p.second_cr   = p.first_cr;
    end
    p.last_pixel = ($urandom_range(0, 11) == 0);
    return p;
  endfunction

  function automatic logic [7:0] random_threshold();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  // one pixel transfer, with an optional gap in front of it
  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    gap = (idle_free || $urandom_range(0, 1) == 0) ? 0 : pause_length();
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    {pix_ch.first_luma, pix_ch.first_cb, pix_ch.first_cr, pix_ch.second_luma,
     pix_ch.second_cb, pix_ch.second_cr, pix_ch.last_pixel} <= p;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // stop the pixel stream and let every awaited result drain
  task automatic quiesce();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // cfg.valid stays high across back-to-back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [7:0] thr, input compare_mode_t mode,
                           input channel_mode_t chan, input bit poke_spare);
    quiesce();
    if (poke_spare) write_reg(REG_SPARE, 8'($urandom));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_COMPARE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_CHANNEL_MODE, CFG_DATA_W'(chan));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned chunk;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    pix_ch.valid <= 1'b0;
    {pix_ch.first_luma, pix_ch.first_cb, pix_ch.first_cr, pix_ch.second_luma,
     pix_ch.second_cb, pix_ch.second_cr, pix_ch.last_pixel} <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 0, count mode, all channels
    send_pixel(pix_of(0, 0, 0, 0, 0, 0, 0));
    send_pixel(pix_of(255, 255, 255, 0, 0, 0, 0));
    send_pixel(pix_of(0, 0, 0, 255, 255, 255, 0));
    // only one chroma sample differs, by one
    send_pixel(pix_of(7, 8, 9, 7, 8, 10, 0));
    // unchanged last pixel: total shown, then cleared
    send_pixel(pix_of(128, 64, 32, 128, 64, 32, 1));

    // threshold equal to the difference: no contribution
    configure(8'd255, MODE_COUNT, CH_ALL, 1'b0);
    send_pixel(pix_of(255, 0, 255, 0, 255, 0, 0));
    send_pixel(pix_of(0, 0, 0, 0, 0, 0, 1));

    // threshold one below and at the difference
    configure(8'd10, MODE_COUNT, CH_ALL, 1'b0);
    send_pixel(pix_of(20, 0, 0, 10, 0, 0, 0));
    send_pixel(pix_of(21, 0, 0, 10, 0, 0, 0));
    send_pixel(pix_of(0, 50, 0, 0, 60, 0, 1));

    // magnitude mode ignores the threshold; sum clamped at 255
    configure(8'd200, MODE_MAGNITUDE, CH_ALL, 1'b0);
    send_pixel(pix_of(255, 255, 255, 0, 0, 0, 0));
    send_pixel(pix_of(100, 100, 55, 0, 0, 0, 0));
    send_pixel(pix_of(10, 0, 0, 0, 0, 3, 0));
    send_pixel(pix_of(1, 1, 1, 1, 1, 1, 1));

    // single-channel selections
    configure(8'd0, MODE_MAGNITUDE, CH_Y, 1'b0);
    send_pixel(pix_of(200, 0, 0, 10, 255, 255, 0));
    configure(8'd0, MODE_MAGNITUDE, CH_U, 1'b0);
    send_pixel(pix_of(200, 0, 0, 10, 255, 255, 0));
    configure(8'd0, MODE_COUNT, CH_V, 1'b0);
    send_pixel(pix_of(200, 0, 0, 10, 255, 255, 0));
    send_pixel(pix_of(200, 0, 5, 10, 255, 5, 1));

    // write to the spare index ahead of the settings; the block must drop it
    configure(8'd5, MODE_COUNT, CH_Y, 1'b1);
    send_pixel(pix_of(0, 9, 9, 5, 0, 0, 0));
    send_pixel(pix_of(0, 9, 9, 6, 0, 0, 1));

    // random phases, each with its own settings and idling style
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_free = ($urandom_range(0, 3) == 0);
      configure(random_threshold(), compare_mode_t'($urandom_range(0, 1)),
                channel_mode_t'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
      chunk = $urandom_range(20, 80);
      repeat (chunk) begin
        send_pixel(random_pixel());
        sent++;
      end
    end

    // drain, then give any stray result time to show
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
